### hw/rtl/mtsv_pkg.sv
// mtsv_pkg: parser state codes, byte classes and the step result type
// for the media type stream validator. no dependencies.
`default_nettype none

package mtsv_pkg;

	typedef enum logic [3:0] {
		ST_LEAD = 4'd0,
		ST_TYPE = 4'd1,
		ST_SUB0 = 4'd2,
		ST_SUB  = 4'd3,
		ST_TAIL = 4'd4,
		ST_NWS  = 4'd5,
		ST_NAME = 4'd6,
		ST_EQWS = 4'd7,
		ST_VWS  = 4'd8,
		ST_VTOK = 4'd9,
		ST_QSTR = 4'd10,
		ST_QESC = 4'd11,
		ST_ERR  = 4'd12
	} parse_state_t;

	localparam logic [7:0] CH_HTAB  = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic         emit;
		logic [7:0]   norm_byte;
		logic         accepted;
		parse_state_t next;
	} step_res_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5a);
	endfunction

	function automatic logic tok_byte(input logic [7:0] c);
		logic alnum;
		logic mark;
		alnum = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7a))
			|| is_upper(c);
		// ! # $ % & ' * + - . ^ _ ` | ~
		mark = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25)
			|| (c == 8'h26) || (c == 8'h27) || (c == 8'h2a) || (c == 8'h2b)
			|| (c == 8'h2d) || (c == 8'h2e) || (c == 8'h5e) || (c == 8'h5f)
			|| (c == 8'h60) || (c == 8'h7c) || (c == 8'h7e);
		return alnum || mark;
	endfunction

	function automatic logic ws_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_HTAB);
	endfunction

	function automatic logic bad_ctl(input logic [7:0] c);
		return ((c < CH_SPACE) && (c != CH_HTAB)) || (c == CH_DEL);
	endfunction

	function automatic logic [7:0] lower_byte(input logic [7:0] c);
		return is_upper(c) ? (c | CASE_BIT) : c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mtsv_stream_if.sv
// mtsv_in_if / mtsv_out_if: valid/ready channels for raw bytes and results
// of the media type stream validator. no dependencies.
`default_nettype none

interface mtsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface mtsv_out_if;
	logic       valid;
	logic       ready;
	logic       emit;
	logic [7:0] norm_byte;
	logic       done_res;
	logic       accepted;

	modport source (output valid, output emit, output norm_byte, output done_res,
		output accepted, input ready);
	modport sink (input valid, input emit, input norm_byte, input done_res,
		input accepted, output ready);
endinterface

`default_nettype wire

### hw/rtl/mtsv_step.sv
// mtsv_step: one grammar step of the media type parser, combinational.
// depends on mtsv_pkg.
`default_nettype none

module mtsv_step
	import mtsv_pkg::*;
(
	input  parse_state_t state,
	input  logic [7:0]   in_byte,
	input  logic         last,
	output step_res_t    res
);

	logic tok;
	logic ws;

	assign tok = tok_byte(in_byte);
	assign ws  = ws_byte(in_byte);

	always_comb begin
		res.emit      = 1'b0;
		res.norm_byte = 8'h00;
		res.next      = ST_ERR;
		unique case (state)
			ST_LEAD: begin
				if (ws) begin
					res.next = ST_LEAD;
				end else if (tok) begin
					res.next      = ST_TYPE;
					res.emit      = 1'b1;
					res.norm_byte = lower_byte(in_byte);
				end
			end
			ST_TYPE: begin
				if (tok) begin
					res.next      = ST_TYPE;
					res.emit      = 1'b1;
					res.norm_byte = lower_byte(in_byte);
				end else if (in_byte == CH_SLASH) begin
					res.next      = ST_SUB0;
					res.emit      = 1'b1;
					res.norm_byte = CH_SLASH;
				end
			end
			ST_SUB0: begin
				if (tok) begin
					res.next      = ST_SUB;
					res.emit      = 1'b1;
					res.norm_byte = lower_byte(in_byte);
				end
			end
			ST_SUB: begin
				if (tok) begin
					res.next      = ST_SUB;
					res.emit      = 1'b1;
					res.norm_byte = lower_byte(in_byte);
				end else if (ws) begin
					res.next = ST_TAIL;
				end else if (in_byte == CH_SEMI) begin
					res.next = ST_NWS;
				end
			end
			ST_TAIL: begin
				if (ws) res.next = ST_TAIL;
				else if (in_byte == CH_SEMI) res.next = ST_NWS;
			end
			ST_NWS: begin
				if (ws) res.next = ST_NWS;
				else if (tok) res.next = ST_NAME;
			end
			ST_NAME: begin
				if (tok) res.next = ST_NAME;
				else if (ws) res.next = ST_EQWS;
				else if (in_byte == CH_EQ) res.next = ST_VWS;
			end
			ST_EQWS: begin
				if (ws) res.next = ST_EQWS;
				else if (in_byte == CH_EQ) res.next = ST_VWS;
			end
			ST_VWS: begin
				if (ws) res.next = ST_VWS;
				else if (in_byte == CH_DQUOT) res.next = ST_QSTR;
				else if (tok) res.next = ST_VTOK;
			end
			ST_VTOK: begin
				if (tok) res.next = ST_VTOK;
				else if (ws) res.next = ST_TAIL;
				else if (in_byte == CH_SEMI) res.next = ST_NWS;
			end
			ST_QSTR: begin
				if (in_byte == CH_DQUOT) res.next = ST_TAIL;
				else if (in_byte == CH_BSL) res.next = ST_QESC;
				else if (!bad_ctl(in_byte)) res.next = ST_QSTR;
			end
			ST_QESC: begin
				if (!bad_ctl(in_byte)) res.next = ST_QSTR;
			end
			default: begin
				// error state and unused codes stay in error
				res.next = ST_ERR;
			end
		endcase
		res.accepted = last
			&& ((res.next == ST_SUB) || (res.next == ST_TAIL) || (res.next == ST_VTOK));
	end

endmodule

`default_nettype wire

### hw/rtl/media_type_stream_validator_top.sv
// Media type stream validator. Takes one header byte per request and
// gives one result per byte: the lowercased type, '/' and subtype bytes
// as they arrive, and on the byte marked last an accept or reject verdict,
// after which the parser is back at its start. Bytes emitted before a
// reject are to be dropped by the user. The block takes one byte every
// cycle while its results are taken; a byte is registered, stepped
// through the grammar against the single state register and its result
// registered in turn. The state register loop is the only feedback.
// depends on mtsv_pkg, mtsv_stream_if and mtsv_step.
`default_nettype none

module media_type_stream_validator_top
	import mtsv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mtsv_in_if.sink    text,
	mtsv_out_if.source result
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	logic         valid_s2;
	logic         emit_s2;
	logic [7:0]   norm_s2;
	logic         done_s2;
	logic         acc_s2;

	parse_state_t state_q;
	step_res_t    step;
	logic         adv_s1;
	logic         take_in;

	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign text.ready = !valid_s1 || adv_s1;
	assign take_in    = text.valid && text.ready;

	mtsv_step u_step (
		.state   (state_q),
		.in_byte (byte_s1),
		.last    (last_s1),
		.res     (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= ST_LEAD;
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;

			if (adv_s1) valid_s2 <= 1'b1;
			else if (result.ready) valid_s2 <= 1'b0;

			if (adv_s1) state_q <= last_s1 ? ST_LEAD : step.next;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.last;
		end
		if (adv_s1) begin
			emit_s2 <= step.emit;
			norm_s2 <= step.norm_byte;
			done_s2 <= last_s1;
			acc_s2  <= step.accepted;
		end
	end

	assign result.valid     = valid_s2;
	assign result.emit      = emit_s2;
	assign result.norm_byte = norm_s2;
	assign result.done_res  = done_s2;
	assign result.accepted  = acc_s2;

endmodule

`default_nettype wire

### hw/rtl/mtsv_checker.sv
// mtsv_checker: port level checks on the media type stream validator
// results, bound to media_type_stream_validator_top. no package needed.
`default_nettype none

module mtsv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       emit,
	input logic [7:0] norm_byte,
	input logic       done_res,
	input logic       accepted
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(emit) && $stable(norm_byte)
			&& $stable(done_res) && $stable(accepted))
		else $error("result changed while stalled");

	// no byte means a zero byte field
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !emit |-> norm_byte == 8'h00)
		else $error("norm_byte set without emit");

	// a verdict only comes with the last byte
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> done_res)
		else $error("accept without done");

	// emitted bytes are never uppercase and never zero
	a_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && emit |-> norm_byte != 8'h00
			&& !((norm_byte >= 8'h41) && (norm_byte <= 8'h5a)))
		else $error("emitted byte not normalized");

endmodule

bind media_type_stream_validator_top mtsv_checker u_mtsv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.emit      (result.emit),
	.norm_byte (result.norm_byte),
	.done_res  (result.done_res),
	.accepted  (result.accepted)
);

`default_nettype wire

### test/media_type_stream_validator_top_tb.sv
// testbench for media_type_stream_validator_top: byte-level grammar predictor,
// directed and random header texts under sender and receiver stalls.
// depends on mtsv_pkg, mtsv_stream_if and the rtl of the top level.
`default_nettype none

module media_type_stream_validator_top_tb
	import mtsv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic       emit;
		logic [7:0] norm_byte;
		logic       done_res;
		logic       accepted;
	} byte_result_t;

	logic clk;
	logic arst_n;

	mtsv_in_if  text_if ();
	mtsv_out_if res_if ();

	media_type_stream_validator_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (res_if)
	);

	byte_result_t byte_results_due[$];
	byte_result_t head_res;
	parse_state_t grammar_pos = ST_LEAD;
	logic [7:0]   text_buf[$];
	int           fail_count = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	int           cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** media_type_stream_validator_top: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- grammar predictor

	function automatic logic is_tchar(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
			8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e};
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_HTAB;
	endfunction

	function automatic logic is_ctl_reject(input logic [7:0] c);
		return (c < CH_SPACE && c != CH_HTAB) || c == CH_DEL;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
	endfunction

	function automatic byte_result_t parse_byte(input logic [7:0] c, input logic lst);
		parse_state_t nx;
		logic         em;
		logic [7:0]   nb;
		logic         tk;
		logic         ws;
		byte_result_t r;
		nx = ST_ERR;
		em = 1'b0;
		nb = 8'h00;
		tk = is_tchar(c);
		ws = is_blank(c);
		case (grammar_pos)
			ST_LEAD: begin
				if (ws) nx = ST_LEAD;
				else if (tk) begin nx = ST_TYPE; em = 1'b1; nb = fold_case(c); end
			end
			ST_TYPE: begin
				if (tk) begin nx = ST_TYPE; em = 1'b1; nb = fold_case(c); end
				else if (c == CH_SLASH) begin nx = ST_SUB0; em = 1'b1; nb = c; end
			end
			ST_SUB0: begin
				if (tk) begin nx = ST_SUB; em = 1'b1; nb = fold_case(c); end
			end
			ST_SUB: begin
				if (tk) begin nx = ST_SUB; em = 1'b1; nb = fold_case(c); end
				else if (ws) nx = ST_TAIL;
				else if (c == CH_SEMI) nx = ST_NWS;
			end
			ST_TAIL: begin
				if (ws) nx = ST_TAIL;
				else if (c == CH_SEMI) nx = ST_NWS;
			end
			ST_NWS: begin
				if (ws) nx = ST_NWS;
				else if (tk) nx = ST_NAME;
			end
			ST_NAME: begin
				if (tk) nx = ST_NAME;
				else if (ws) nx = ST_EQWS;
				else if (c == CH_EQ) nx = ST_VWS;
			end
			ST_EQWS: begin
				if (ws) nx = ST_EQWS;
				else if (c == CH_EQ) nx = ST_VWS;
			end
			ST_VWS: begin
				if (ws) nx = ST_VWS;
				else if (c == CH_DQUOT) nx = ST_QSTR;
				else if (tk) nx = ST_VTOK;
			end
			ST_VTOK: begin
				if (tk) nx = ST_VTOK;
				else if (ws) nx = ST_TAIL;
				else if (c == CH_SEMI) nx = ST_NWS;
			end
			ST_QSTR: begin
				if (c == CH_DQUOT) nx = ST_TAIL;
				else if (c == CH_BSL) nx = ST_QESC;
				else if (!is_ctl_reject(c)) nx = ST_QSTR;
			end
			ST_QESC: begin
				if (!is_ctl_reject(c)) nx = ST_QSTR;
			end
			default: begin
			end
		endcase
		r.emit      = em;
		r.norm_byte = em ? nb : 8'h00;
		r.done_res  = lst;
		r.accepted  = lst && (nx inside {ST_SUB, ST_TAIL, ST_VTOK});
		grammar_pos = lst ? ST_LEAD : nx;
		return r;
	endfunction

	// ---------------------------------------------------------------- text builders

	function automatic void add_byte(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_tchar();
		logic [7:0] c;
		c = 8'(($urandom_range(33, 126)));
		while (!is_tchar(c)) c = 8'($urandom_range(33, 126));
		return c;
	endfunction

	function automatic void push_token(input int lo, input int hi);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) add_byte(pick_tchar());
	endfunction

	function automatic void push_blanks();
		int n;
		n = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) add_byte($urandom_range(1) ? CH_SPACE : CH_HTAB);
	endfunction

	function automatic logic [7:0] pick_qbyte();
		logic [7:0] c;
		c = 8'($urandom_range(32, 255));
		while (c == CH_DQUOT || c == CH_BSL || c == CH_DEL) c = 8'($urandom_range(32, 255));
		return c;
	endfunction

	function automatic void push_quoted();
		int         n;
		logic [7:0] c;
		n = $urandom_range(0, 4);
		add_byte(CH_DQUOT);
		repeat (n) begin
			case ($urandom_range(3))
				0: begin
					add_byte(CH_BSL);
					// mostly legal escapes, sometimes any byte at all
					c = 8'($urandom_range(255));
					if ($urandom_range(9) != 0)
						while (is_ctl_reject(c)) c = 8'($urandom_range(255));
					add_byte(c);
				end
				1: add_byte(CH_HTAB);
				default: add_byte(($urandom_range(19) == 0) ?
					8'($urandom_range(255)) : pick_qbyte());
			endcase
		end
		add_byte(CH_DQUOT);
	endfunction

	function automatic void build_media_type();
		int np;
		int r;
		int pos;
		text_buf.delete();
		push_blanks();
		push_token(1, 4);
		add_byte(CH_SLASH);
		push_token(1, 4);
		np = $urandom_range(0, 2);
		repeat (np) begin
			push_blanks();
			add_byte(CH_SEMI);
			push_blanks();
			push_token(1, 3);
			push_blanks();
			add_byte(CH_EQ);
			push_blanks();
			if ($urandom_range(1)) push_token(1, 3);
			else push_quoted();
		end
		push_blanks();
		r = $urandom_range(99);
		pos = $urandom_range(text_buf.size() - 1);
		if (r < 8) begin
			text_buf.delete();
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
		end else if (r < 18) begin
			text_buf[pos] = 8'($urandom_range(255));
		end else if (r < 24) begin
			text_buf[pos] = ($urandom_range(3) == 0) ? CH_DEL : 8'($urandom_range(31));
		end else if (r < 32) begin
			while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
		end
	endfunction

	// ---------------------------------------------------------------- driving

	initial begin
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.in_byte = 8'h00;
		text_if.last = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// receiver: long hold first, otherwise random stall
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			text_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= b;
		text_if.last    <= lst;
		do @(posedge clk); while (!text_if.ready);
		byte_results_due.insert(byte_results_due.size(), parse_byte(b, lst));
	endtask

	task automatic send_text(inout int sent);
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
		sent += text_buf.size();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		text_if.valid <= 1'b0;
		while (byte_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (byte_results_due.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				head_res = byte_results_due.pop_front();
				check_field("emit", 8'(head_res.emit), 8'(res_if.emit));
				check_field("norm_byte", head_res.norm_byte, res_if.norm_byte);
				check_field("done_res", 8'(head_res.done_res), 8'(res_if.done_res));
				check_field("accepted", 8'(head_res.accepted), 8'(res_if.accepted));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		int sent;
		sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		// non-ascii and nul bytes alone
		text_buf = '{8'hff};
		send_text(sent);
		text_buf = '{8'h00};
		send_text(sent);
		// leading tab, uppercase type, ends in subtype
		text_buf.delete();
		add_byte(CH_HTAB);
		push_str("Z/a");
		send_text(sent);
		// quoted value with high byte and escaped quote, ends in tail
		text_buf.delete();
		push_str("a/b;k=\"");
		add_byte(8'h80);
		push_str("\\\"\"");
		send_text(sent);
		// ends in a token value
		text_buf.delete();
		push_str("x/Y;k=v");
		send_text(sent);
		// syntax error then sticky rejection
		text_buf.delete();
		push_str("a?/b");
		send_text(sent);
		wait_drained();
	endtask

	task automatic test_random(input int idle, input int stall, input int count);
		int sent;
		sent = 0;
		idle_pct = idle;
		stall_pct = stall;
		while (sent < count) begin
			build_media_type();
			send_text(sent);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		int sent;
		sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		while (sent < 80) begin
			build_media_type();
			send_text(sent);
		end
		// sender pauses until every result is back
		wait_drained();
		hold_left = 120;
		sent = 0;
		while (sent < 70) begin
			build_media_type();
			send_text(sent);
		end
		wait_drained();
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random(0, 0, 340);
		test_random(75, 0, 340);
		test_random(0, 75, 340);
		test_random(34, 34, 340);
		test_backpressure();
		if (fail_count == 0)
			$display("** media_type_stream_validator_top: PASSED **");
		else
			$display("** media_type_stream_validator_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
